@@ src/plt_pkg.sv @@
// shared constants, codes and controller/datapath interface types for the list table
`timescale 1ns / 1ps
package plt_pkg;

	localparam int CAPACITY  = 64;
	localparam int ADDR_W    = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int ACT_W     = 2;
	localparam int POS_W     = 7;
	localparam int VAL_W     = 32;
	localparam int ST_W      = 2;
	localparam int FOUND_W   = 6;
	localparam int COUNT_W   = 7;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 16;

	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd3;

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_BAD_POS   = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic load;
		logic init;
		logic walk;
		logic commit;
		logic respond;
	} plt_cmd_t;

	typedef struct packed {
		logic             walk_done;
		logic             out_free;
		logic [CNT_W-1:0] count;
	} plt_stat_t;

endpackage

@@ src/plt_datapath.sv @@
// list table datapath: entry memory, walk cursor, compare and result registers
`timescale 1ns / 1ps
module plt_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  plt_pkg::plt_cmd_t              cmd,
	output plt_pkg::plt_stat_t             stat,
	input  logic [plt_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic [plt_pkg::ACT_W-1:0]      s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [plt_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic [plt_pkg::ST_W-1:0]       m_tuser
);
	import plt_pkg::*;

	logic [VAL_W-1:0]     mem [CAPACITY];

	logic [ACT_W-1:0]     act_q;
	logic [POS_W-1:0]     pos_q;
	logic [VAL_W-1:0]     val_q;
	logic [CNT_W-1:0]     count_q;
	logic [ADDR_W-1:0]    ptr_q;
	logic [CNT_W-1:0]     rem_q;
	logic                 pend_s1;
	logic [ADDR_W-1:0]    addr_s1;
	logic [VAL_W-1:0]     rd_data_s1;
	logic [ST_W-1:0]      status_q;
	logic                 hit_q;
	logic [ADDR_W-1:0]    found_q;
	logic [ST_W-1:0]      res_status_q;
	logic [ADDR_W-1:0]    res_found_q;
	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [ST_W-1:0]      m_tuser_q;

	logic                 ins_bad;
	logic                 ins_full;
	logic                 rem_bad;
	logic                 hit_now;
	logic                 issue;
	logic                 out_free;
	logic                 wr_en;
	logic [ADDR_W-1:0]    wr_addr;
	logic [VAL_W-1:0]     wr_data;
	logic [ST_W-1:0]      fin_status;

	assign ins_bad  = pos_q > POS_W'(count_q);
	assign ins_full = count_q >= CNT_W'(CAPACITY);
	assign rem_bad  = pos_q >= POS_W'(count_q);
	assign hit_now  = cmd.walk && pend_s1 && (act_q == ACT_SEARCH) && (rd_data_s1 == val_q);
	assign issue    = cmd.walk && (rem_q != '0) && !hit_now;
	assign out_free = !m_tvalid_q || m_tready;

	assign stat.walk_done = ((rem_q == '0) && !pend_s1) || hit_now;
	assign stat.out_free  = out_free;
	assign stat.count     = count_q;

	assign fin_status = ((status_q == ST_OK) && (act_q == ACT_SEARCH) && !hit_q) ?
		ST_NOT_FOUND : status_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_s1;
		wr_data = rd_data_s1;
		if (cmd.walk && pend_s1 && (act_q == ACT_INSERT)) begin
			wr_en   = 1'b1;
			wr_addr = addr_s1 + ADDR_W'(1);
		end else if (cmd.walk && pend_s1 && (act_q == ACT_REMOVE)) begin
			wr_en   = 1'b1;
			wr_addr = addr_s1 - ADDR_W'(1);
		end else if (cmd.commit && (act_q == ACT_INSERT) && (status_q == ST_OK)) begin
			wr_en   = 1'b1;
			wr_addr = pos_q[ADDR_W-1:0];
			wr_data = val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (issue) begin
			rd_data_s1 <= mem[ptr_q];
			addr_s1    <= ptr_q;
		end
	end

	// latched transaction and walk bookkeeping
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= s_tuser;
			pos_q <= s_tdata[POS_W-1:0];
			val_q <= s_tdata[POS_W +: VAL_W];
		end
		if (cmd.init) begin
			hit_q   <= 1'b0;
			found_q <= '0;
			unique case (act_q)
				ACT_INSERT: begin
					ptr_q <= ADDR_W'(count_q - CNT_W'(1));
					if (ins_bad) begin
						status_q <= ST_BAD_POS;
					end else if (ins_full) begin
						status_q <= ST_FULL;
					end else begin
						status_q <= ST_OK;
					end
				end
				ACT_REMOVE: begin
					ptr_q    <= ADDR_W'(pos_q + POS_W'(1));
					status_q <= rem_bad ? ST_BAD_POS : ST_OK;
				end
				ACT_SEARCH: begin
					ptr_q    <= '0;
					status_q <= ST_OK;
				end
				default: begin
					ptr_q    <= '0;
					status_q <= ST_OK;
				end
			endcase
		end else if (issue) begin
			ptr_q <= (act_q == ACT_INSERT) ? ptr_q - ADDR_W'(1) : ptr_q + ADDR_W'(1);
		end
		if (hit_now) begin
			hit_q   <= 1'b1;
			found_q <= addr_s1;
		end
		if (cmd.commit) begin
			res_status_q <= fin_status;
			res_found_q  <= found_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rem_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= issue;
			if (cmd.init) begin
				unique case (act_q)
					ACT_INSERT: begin
						rem_q <= (ins_bad || ins_full) ? '0 : count_q - CNT_W'(pos_q);
					end
					ACT_REMOVE: begin
						rem_q <= rem_bad ? '0 : count_q - CNT_W'(pos_q) - CNT_W'(1);
					end
					ACT_SEARCH: begin
						rem_q <= count_q;
					end
					default: begin
						rem_q <= '0;
					end
				endcase
			end else if (issue) begin
				rem_q <= rem_q - CNT_W'(1);
			end else if (hit_now) begin
				rem_q <= '0;
			end
			if (cmd.commit) begin
				if (act_q == ACT_CLEAR) begin
					count_q <= '0;
				end else if (act_q == ACT_INSERT && status_q == ST_OK) begin
					count_q <= count_q + CNT_W'(1);
				end else if (act_q == ACT_REMOVE && status_q == ST_OK) begin
					count_q <= count_q - CNT_W'(1);
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.respond) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.respond) begin
			m_tdata_q <= M_TDATA_W'({COUNT_W'(count_q), FOUND_W'(res_found_q)});
			m_tuser_q <= res_status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

@@ src/plt_ctrl.sv @@
// list table controller state machine
`timescale 1ns / 1ps
module plt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  plt_pkg::plt_stat_t stat,
	output plt_pkg::plt_cmd_t  cmd
);
	import plt_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_WALK   = 3'd2;
	localparam logic [2:0] S_COMMIT = 3'd3;
	localparam logic [2:0] S_RESP   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		cmd       = '0;
		s_tready  = 1'b0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load  = 1'b1;
					state_nxt = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.init  = 1'b1;
				state_nxt = S_WALK;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (stat.walk_done) begin
					state_nxt = S_COMMIT;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_nxt  = S_RESP;
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.respond = 1'b1;
					state_nxt   = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

@@ src/positional_list_table.sv @@
// top level of the positional list table
`timescale 1ns / 1ps
// Ordered list of up to 64 32-bit values held in a single-port-read table memory.
// One transaction is worked at a time. The entries it covers are walked one per cycle
// through the memory read port: count - position for insert, count - position - 1 for
// remove and count for a search with no match. Nothing is walked for clear, rejected
// actions, insert at the tail, remove of the last entry or a search of an empty list.
// A search stops at its first match. The result waits in an output register, so a new
// transaction is taken while the previous result is still pending.
module positional_list_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [plt_pkg::S_TDATA_W-1:0] s_tdata,  // position[6:0], value[38:7]
	input  logic [plt_pkg::ACT_W-1:0]     s_tuser,  // action[1:0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [plt_pkg::M_TDATA_W-1:0] m_tdata,  // found_position[5:0], entry_count[12:6]
	output logic [plt_pkg::ST_W-1:0]      m_tuser   // status[1:0]
);
	import plt_pkg::*;

	plt_cmd_t  cmd;
	plt_stat_t stat;

	plt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	plt_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second transaction taken while one is in progress");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk |-> !s_tready)
		else $error("table walk while input is open");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.respond |-> stat.out_free)
		else $error("result overwrites a pending result");

endmodule
